[sv/psd_pkg.sv]
// Shared types, constants and the CRC-32 byte step for the PNG stored-deflate encoder.
// No dependencies.
package psd_pkg;

    localparam int unsigned MaxSide        = 4096;
    localparam int unsigned StoredBlockMax = 65535;
    localparam int unsigned AdlerMod       = 65521;
    localparam logic [31:0] CrcPoly        = 32'hEDB88320;
    localparam int unsigned SideW          = 13;
    localparam int unsigned RowBytesW      = 15;
    localparam int unsigned TotalW         = 27;
    localparam int unsigned IdxW           = 5;

    localparam logic [7:0] ZlibCmf = 8'h78;
    localparam logic [7:0] ZlibFlg = 8'h01;

    localparam logic [7:0] PngSig [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                          8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [7:0] IendChunk [12] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                              8'h49, 8'h45, 8'h4E, 8'h44,
                                              8'hAE, 8'h42, 8'h60, 8'h82};
    localparam logic [7:0] IdatType [4] = '{8'h49, 8'h44, 8'h41, 8'h54};

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SIG, ST_IHLEN, ST_IHDR, ST_IHCRC, ST_IDLEN, ST_IDTYPE,
        ST_ZHDR, ST_SCAN, ST_BHDR, ST_DATA, ST_CHK, ST_ADLER, ST_CRC,
        ST_IEND, ST_WAIT, ST_DONE
    } t_state;

    typedef struct packed {
        t_state state;
        logic   emit;
        logic   idx_inc;
        logic   idx_clr;
        logic   crc_init;
        logic   crc_upd;
        logic   accept;
        logic   start;
        logic   data_step;
        logic   idle;
        logic   done;
    } t_cmd;

    typedef struct packed {
        logic [IdxW-1:0] idx;
        logic            fill_zero;
        logic            filt;
        logic            img_done;
        logic            out_free;
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
        end
        return r;
    endfunction

endpackage

[sv/psd_pix_if.sv]
// Input channel: one RGBA channel byte per beat.
// Standalone interface, no dependencies.
interface psd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    modport source (output valid, output pixel_byte, input ready);
    modport sink (input valid, input pixel_byte, output ready);
endinterface

[sv/psd_out_if.sv]
// Output channel: one PNG file byte per beat, with end-of-file flag.
// Standalone interface, no dependencies.
interface psd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

[sv/psd_ctrl.sv]
// Sequencer for the PNG byte stream: walks the file sections one byte per step.
// Depends on psd_pkg.
module psd_ctrl import psd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   w_emits;
    logic   w_last;
    logic   w_emit;
    logic [IdxW-1:0] w_len_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_emits  = 1'b1;
        w_len_m1 = '0;
        unique case (r_state)
            ST_SIG:    w_len_m1 = IdxW'(7);
            ST_IHLEN:  w_len_m1 = IdxW'(3);
            ST_IHDR:   w_len_m1 = IdxW'(16);
            ST_IHCRC:  w_len_m1 = IdxW'(3);
            ST_IDLEN:  w_len_m1 = IdxW'(3);
            ST_IDTYPE: w_len_m1 = IdxW'(3);
            ST_ZHDR:   w_len_m1 = IdxW'(1);
            ST_BHDR:   w_len_m1 = IdxW'(4);
            ST_DATA:   w_len_m1 = '0;
            ST_ADLER:  w_len_m1 = IdxW'(3);
            ST_CRC:    w_len_m1 = IdxW'(3);
            ST_IEND:   w_len_m1 = IdxW'(11);
            default:   w_emits  = 1'b0;
        endcase
        w_last = (i_status.idx == w_len_m1);
        w_emit = w_emits && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_SIG;
            ST_SIG:    if (w_emit && w_last) n_state = ST_IHLEN;
            ST_IHLEN:  if (w_emit && w_last) n_state = ST_IHDR;
            ST_IHDR:   if (w_emit && w_last) n_state = ST_IHCRC;
            ST_IHCRC:  if (w_emit && w_last) n_state = ST_IDLEN;
            ST_IDLEN:  if (w_emit && w_last) n_state = ST_IDTYPE;
            ST_IDTYPE: if (w_emit && w_last) n_state = ST_ZHDR;
            ST_ZHDR:   if (w_emit && w_last) n_state = ST_SCAN;
            ST_SCAN:   n_state = i_status.fill_zero ? ST_BHDR : ST_DATA;
            ST_BHDR:   if (w_emit && w_last) n_state = ST_DATA;
            ST_DATA:   if (w_emit) n_state = i_status.filt ? ST_SCAN : ST_CHK;
            ST_CHK:    n_state = i_status.img_done ? ST_ADLER : ST_WAIT;
            ST_ADLER:  if (w_emit && w_last) n_state = ST_CRC;
            ST_CRC:    if (w_emit && w_last) n_state = ST_IEND;
            ST_IEND:   if (w_emit && w_last) n_state = ST_DONE;
            ST_WAIT:   if (i_valid) n_state = ST_SCAN;
            ST_DONE:   n_state = ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE) || (r_state == ST_WAIT) || (r_state == ST_DONE);
        o_cmd.state      = r_state;
        o_cmd.emit       = w_emit;
        o_cmd.idx_inc    = w_emit && !w_last;
        o_cmd.idx_clr    = w_emit && w_last;
        o_cmd.crc_init   = w_emit && ((r_state == ST_IHLEN) || (r_state == ST_IDLEN));
        o_cmd.crc_upd    = w_emit && ((r_state == ST_IHDR) || (r_state == ST_IDTYPE)
                           || (r_state == ST_ZHDR) || (r_state == ST_BHDR)
                           || (r_state == ST_DATA) || (r_state == ST_ADLER));
        o_cmd.accept     = o_ready && i_valid;
        o_cmd.start      = (r_state == ST_SIG);
        o_cmd.data_step  = w_emit && (r_state == ST_DATA);
        o_cmd.idle       = (r_state == ST_IDLE);
        o_cmd.done       = (r_state == ST_DONE);
    end

endmodule

[sv/psd_dp.sv]
// Datapath: size registers, length precompute, counters, CRC-32, Adler-32, output register.
// Depends on psd_pkg.
module psd_dp import psd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [SideW-1:0] i_cfg_data,
    input  logic [7:0]       i_pixel_byte,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    input  t_cmd             i_cmd,
    output t_status          o_status
);

    logic [SideW-1:0]     r_width, r_height, w_clamped;
    logic [TotalW-1:0]    r_total;
    logic [10:0]          r_blocks;
    logic [31:0]          r_idat_len;
    logic [IdxW-1:0]      r_idx;
    logic [RowBytesW-1:0] r_bytes_in_row;
    logic [SideW-1:0]     r_rows_done;
    logic [15:0]          r_block_fill;
    logic [TotalW-1:0]    r_left;
    logic [31:0]          r_crc;
    logic [15:0]          r_adler_low, r_adler_high;
    logic                 r_filt;
    logic [7:0]           r_pix;
    logic                 r_ovalid, r_olast;
    logic [7:0]           r_obyte;

    logic [10:0]  w_q;
    logic [16:0]  w_r;
    logic [10:0]  w_blocks;
    logic [7:0]   w_byte;
    logic [7:0]   w_data;
    logic [15:0]  w_len;
    logic         w_final;
    logic [31:0]  w_word;
    logic [1:0]   w_bsel;
    logic [16:0]  w_lo_sum, w_hi_sum;
    logic [15:0]  w_lo_new, w_hi_new;
    logic [RowBytesW-1:0] w_row_next;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_clamped = SideW'(1);
        end else if (i_cfg_data > SideW'(MaxSide)) begin
            w_clamped = SideW'(MaxSide);
        end else begin
            w_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SideW'(1);
            r_height <= SideW'(1);
        end else if (i_cfg_we && i_cmd.idle) begin
            if (i_cfg_idx == CfgWidth) r_width <= w_clamped;
            if (i_cfg_idx == CfgHeight) r_height <= w_clamped;
        end
    end

    // ceil(total / 65535): q = total >> 16, remainder = low half + q, one correction
    always_comb begin
        w_q = r_total[26:16];
        w_r = {1'b0, r_total[15:0]} + {6'd0, w_q};
        if (w_r >= 17'(StoredBlockMax)) begin
            w_q = w_q + 11'd1;
            w_r = w_r - 17'(StoredBlockMax);
        end
        w_blocks = w_q + {10'd0, (w_r != '0)};
    end

    always_ff @(posedge i_clk) begin
        r_total    <= TotalW'(r_height * {r_width, 2'b01});
        r_blocks   <= w_blocks;
        r_idat_len <= 32'(r_total) + 32'd6 + 32'(r_blocks) * 32'd5;
    end

    always_comb begin
        w_row_next = r_bytes_in_row + RowBytesW'(1);
        w_lo_sum   = {1'b0, r_adler_low} + {9'd0, w_data};
        w_lo_new   = (w_lo_sum >= 17'(AdlerMod)) ? 16'(w_lo_sum - 17'(AdlerMod))
                                                 : w_lo_sum[15:0];
        w_hi_sum   = {1'b0, r_adler_high} + {1'b0, w_lo_new};
        w_hi_new   = (w_hi_sum >= 17'(AdlerMod)) ? 16'(w_hi_sum - 17'(AdlerMod))
                                                 : w_hi_sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx          <= '0;
            r_bytes_in_row <= '0;
            r_rows_done    <= '0;
            r_block_fill   <= '0;
            r_left         <= '0;
            r_crc          <= '1;
            r_adler_low    <= 16'd1;
            r_adler_high   <= '0;
            r_filt         <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IdxW'(1);
            end
            if (i_cmd.start) r_left <= r_total;
            if (i_cmd.accept && !i_cmd.done) r_filt <= (r_bytes_in_row == '0);
            if (i_cmd.crc_init) begin
                r_crc <= '1;
            end else if (i_cmd.crc_upd) begin
                r_crc <= crc_byte(r_crc, w_byte);
            end
            if (i_cmd.data_step) begin
                r_adler_low  <= w_lo_new;
                r_adler_high <= w_hi_new;
                r_block_fill <= (r_block_fill + 16'd1 >= 16'(StoredBlockMax))
                                ? '0 : r_block_fill + 16'd1;
                if (r_left != '0) r_left <= r_left - TotalW'(1);
                if (r_filt) begin
                    r_filt <= 1'b0;
                end else if (w_row_next >= {r_width, 2'b00}) begin
                    r_bytes_in_row <= '0;
                    r_rows_done    <= r_rows_done + SideW'(1);
                end else begin
                    r_bytes_in_row <= w_row_next;
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_pix <= i_pixel_byte;
        if (i_cmd.emit) begin
            r_obyte <= w_byte;
            r_olast <= (i_cmd.state == ST_IEND) && (r_idx == IdxW'(11));
        end
    end

    always_comb begin
        w_data  = r_filt ? 8'd0 : r_pix;
        w_final = (r_left <= TotalW'(StoredBlockMax));
        w_len   = w_final ? r_left[15:0] : 16'(StoredBlockMax);
        w_bsel  = r_idx[1:0];
        w_word  = ~r_crc;
        w_byte  = 8'd0;
        unique case (i_cmd.state)
            ST_ADLER: w_word = {r_adler_high, r_adler_low};
            ST_IDLEN: w_word = r_idat_len;
            default:  w_word = ~r_crc;
        endcase
        unique case (i_cmd.state)
            ST_SIG:    w_byte = PngSig[r_idx[2:0]];
            ST_IHLEN:  w_byte = (r_idx == IdxW'(3)) ? 8'd13 : 8'd0;
            ST_IHDR: begin
                unique case (r_idx)
                    IdxW'(0):  w_byte = 8'h49;
                    IdxW'(1):  w_byte = 8'h48;
                    IdxW'(2):  w_byte = 8'h44;
                    IdxW'(3):  w_byte = 8'h52;
                    IdxW'(6):  w_byte = {3'd0, r_width[12:8]};
                    IdxW'(7):  w_byte = r_width[7:0];
                    IdxW'(10): w_byte = {3'd0, r_height[12:8]};
                    IdxW'(11): w_byte = r_height[7:0];
                    IdxW'(12): w_byte = 8'd8;
                    IdxW'(13): w_byte = 8'd6;
                    default:   w_byte = 8'd0;
                endcase
            end
            ST_IHCRC, ST_IDLEN, ST_ADLER, ST_CRC: begin
                unique case (w_bsel)
                    2'd0: w_byte = w_word[31:24];
                    2'd1: w_byte = w_word[23:16];
                    2'd2: w_byte = w_word[15:8];
                    default: w_byte = w_word[7:0];
                endcase
            end
            ST_IDTYPE: w_byte = IdatType[w_bsel];
            ST_ZHDR:   w_byte = r_idx[0] ? ZlibFlg : ZlibCmf;
            ST_BHDR: begin
                unique case (r_idx)
                    IdxW'(0): w_byte = {7'd0, w_final};
                    IdxW'(1): w_byte = w_len[7:0];
                    IdxW'(2): w_byte = w_len[15:8];
                    IdxW'(3): w_byte = ~w_len[7:0];
                    default:  w_byte = ~w_len[15:8];
                endcase
            end
            ST_DATA:   w_byte = w_data;
            ST_IEND:   w_byte = IendChunk[r_idx[3:0]];
            default:   w_byte = 8'd0;
        endcase
    end

    assign o_out_valid        = r_ovalid;
    assign o_out_byte         = r_obyte;
    assign o_out_last         = r_olast;
    assign o_status.idx       = r_idx;
    assign o_status.fill_zero = (r_block_fill == '0);
    assign o_status.filt      = r_filt;
    assign o_status.img_done  = (r_rows_done >= r_height);
    assign o_status.out_free  = !r_ovalid || i_out_ready;

endmodule

[sv/png_stored_deflate_encoder.sv]
// PNG encoder, 8-bit RGBA, stored deflate. Each accepted pixel byte yields its file bytes
// one per cycle while the output is taken; the first byte also yields the 43-byte file and
// zlib header, each row start a filter byte, every 65535 scanline bytes a 5-byte block
// header, and the last pixel the 20-byte trailer. For each item a block boundary check
// precedes each scanline byte it carries, and its bytes are followed by an image-end
// check, then the wait for input or the trailer; output stalls hold the sequence. The
// block takes no new item until that sequence is done. Sizes are written only before the
// first pixel byte (0 reads as 1, above 4096 as 4096). Bytes after the image are dropped.
module png_stored_deflate_encoder import psd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psd_pix_if.sink          s_pix,
    psd_out_if.source        m_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [SideW-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    psd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_pix.valid),
        .o_ready  (s_pix.ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    psd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_byte (s_pix.pixel_byte),
        .i_out_ready  (m_out.ready),
        .o_out_valid  (m_out.valid),
        .o_out_byte   (m_out.out_byte),
        .o_out_last   (m_out.last_byte),
        .i_cmd        (w_cmd),
        .o_status     (w_status)
    );

    a_nothing_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.ready && m_out.last_byte |=> !m_out.valid)
        else $error("beat after end of file");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pix.valid && s_pix.ready && !w_cmd.done |=> !s_pix.ready)
        else $error("input taken while previous byte in progress");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("output register overwritten");

endmodule

[test/psd_tb_types.sv]
// Testbench-side types for the PNG stored-deflate encoder bench.
// Depends on nothing; used by the testbench top module.
package psd_tb_types;

    typedef struct {
        logic [7:0] data;
        logic       hold;
    } t_pix_item;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_file_byte;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STREAM,
        PH_DONE
    } t_phase;

endpackage

[test/testbench.sv]
// Testbench for png_stored_deflate_encoder: pixel bytes go in with random gaps, the PNG
// file bytes are checked one by one against an in-bench predictor of the whole file.
// Depends on psd_pkg, psd_pix_if, psd_out_if, psd_tb_types and png_stored_deflate_encoder.
module testbench;
    import psd_pkg::*;
    import psd_tb_types::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [SideW-1:0] cfg_data;

    psd_pix_if pix();
    psd_out_if out_ch();

    png_stored_deflate_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_pix      (pix.sink),
        .m_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_pix_item   pix_pending[$];
    t_file_byte  file_due[$];
    int unsigned mismatches;

    // predictor state
    int unsigned img_w, img_h, row_bytes, rows_seen, block_fill, scan_left;
    int unsigned adler_lo, adler_hi;
    logic [31:0] idat_crc;
    t_phase      phase;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void due_byte(logic [7:0] b, logic lst);
        file_due.insert(file_due.size(), t_file_byte'{data: b, last: lst});
    endfunction

    function automatic void due_idat(logic [7:0] b);
        due_byte(b, 1'b0);
        idat_crc = crc_step(idat_crc, b);
    endfunction

    function automatic void due_be32(logic [31:0] v, logic in_idat);
        for (int k = 3; k >= 0; k--) begin
            if (in_idat) due_idat(v[8*k +: 8]);
            else due_byte(v[8*k +: 8], 1'b0);
        end
    endfunction

    function automatic int unsigned side_clamp(logic [SideW-1:0] v);
        if (v == 0) return 1;
        if (v > MaxSide) return MaxSide;
        return v;
    endfunction

    function automatic void apply_cfg(logic idx, logic [SideW-1:0] v);
        if (phase != PH_IDLE) return;
        if (idx == CfgWidth) img_w = side_clamp(v);
        else img_h = side_clamp(v);
    endfunction

    function automatic void due_header();
        logic [7:0]  ihdr[17];
        logic [31:0] c;
        int unsigned total, blocks;
        c = 32'hFFFFFFFF;
        foreach (PngSig[k]) due_byte(PngSig[k], 1'b0);
        ihdr = '{8'h49, 8'h48, 8'h44, 8'h52, 8'h00, 8'h00, img_w[15:8], img_w[7:0],
                 8'h00, 8'h00, img_h[15:8], img_h[7:0], 8'd8, 8'd6, 8'd0, 8'd0, 8'd0};
        due_be32(32'd13, 1'b0);
        foreach (ihdr[k]) begin
            due_byte(ihdr[k], 1'b0);
            c = crc_step(c, ihdr[k]);
        end
        due_be32(~c, 1'b0);
        total  = img_h * (img_w * 4 + 1);
        blocks = (total + StoredBlockMax - 1) / StoredBlockMax;
        scan_left = total;
        due_be32(2 + total + 5 * blocks + 4, 1'b0);
        idat_crc = 32'hFFFFFFFF;
        foreach (IdatType[k]) due_idat(IdatType[k]);
        due_idat(ZlibCmf);
        due_idat(ZlibFlg);
        phase = PH_STREAM;
    endfunction

    function automatic void due_scan(logic [7:0] b);
        int unsigned len;
        logic [15:0] nlen;
        if (block_fill == 0) begin
            len  = (scan_left > StoredBlockMax) ? StoredBlockMax : scan_left;
            nlen = ~len[15:0];
            due_idat((scan_left <= StoredBlockMax) ? 8'd1 : 8'd0);
            due_idat(len[7:0]);
            due_idat(len[15:8]);
            due_idat(nlen[7:0]);
            due_idat(nlen[15:8]);
        end
        due_idat(b);
        adler_lo = (adler_lo + b) % AdlerMod;
        adler_hi = (adler_hi + adler_lo) % AdlerMod;
        block_fill++;
        if (block_fill >= StoredBlockMax) block_fill = 0;
        if (scan_left > 0) scan_left--;
    endfunction

    function automatic void predict_pixel(logic [7:0] b);
        if (phase == PH_DONE) return;
        if (phase == PH_IDLE) due_header();
        if (row_bytes == 0) due_scan(8'd0);
        due_scan(b);
        row_bytes++;
        if (row_bytes >= img_w * 4) begin
            row_bytes = 0;
            rows_seen++;
        end
        if (rows_seen >= img_h) begin
            due_be32({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
            due_be32(~idat_crc, 1'b0);
            foreach (IendChunk[k]) due_byte(IendChunk[k], k == 11);
            phase = PH_DONE;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int unsigned draw_wait(bit no_idle);
        if (no_idle || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    // pixel driver
    int unsigned send_wait;
    bit          send_burst;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            send_wait = 0;
            send_burst = 1'b0;
        end else begin
            if (pix.valid && pix.ready) predict_pixel(pix.pixel_byte);
            if (!(pix.valid && !pix.ready)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    pix.valid <= 1'b0;
                end else if (pix_pending.size() > 0 &&
                             !(pix_pending[0].hold && file_due.size() > 0)) begin
                    pix.valid      <= 1'b1;
                    pix.pixel_byte <= pix_pending[0].data;
                    void'(pix_pending.pop_front());
                    if ($urandom_range(0, 30) == 0) send_burst = !send_burst;
                    send_wait = draw_wait(send_burst);
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // file byte monitor
    int unsigned take_wait;
    bit          take_burst;
    t_file_byte  want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            take_wait = 0;
            take_burst = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (file_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
                end else begin
                    want = file_due.pop_front();
                    if (out_ch.out_byte !== want.data)
                        report_mismatch($sformatf("byte %02h, want %02h",
                                                  out_ch.out_byte, want.data));
                    if (out_ch.last_byte !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  out_ch.last_byte, want.last));
                end
                if ($urandom_range(0, 30) == 0) take_burst = !take_burst;
                take_wait = draw_wait(take_burst);
            end
            if (take_wait > 0) begin
                take_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(logic idx, logic [SideW-1:0] v);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        apply_cfg(idx, v);
    endtask

    task automatic drain();
        while (pix_pending.size() > 0 || pix.valid) @(posedge i_clk);
        while (file_due.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        int unsigned w, h, n;
        mismatches = 0;
        img_w = 1; img_h = 1; row_bytes = 0; rows_seen = 0; block_fill = 0;
        scan_left = 0; adler_lo = 1; adler_hi = 0; idat_crc = '1; phase = PH_IDLE;
        pix.valid = 1'b0; pix.pixel_byte = '0; out_ch.ready = 1'b0;
        cfg_we = 1'b0; cfg_idx = CfgWidth; cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        w = $urandom_range(1, 12);
        h = 250 / (4 * w);
        cfg_write(CfgWidth, 13'd0);
        cfg_write(CfgHeight, 13'd0);
        cfg_write(CfgWidth, 13'h1FFF);
        cfg_write(CfgHeight, 13'd4097);
        cfg_write(CfgHeight, 13'd4096);
        cfg_write(CfgWidth, w[SideW-1:0]);
        cfg_write(CfgHeight, h[SideW-1:0]);
        @(posedge i_clk);
        cfg_we <= 1'b0;

        n = w * h * 4;
        for (int k = 0; k < n; k++) begin
            logic [7:0] b;
            case (k)
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h55;
                3: b = 8'hAA;
                4: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            pix_pending.insert(pix_pending.size(), t_pix_item'{data: b, hold: (k == n / 2)});
        end
        drain();

        // sizes are locked once the stream has begun; extra bytes are dropped
        cfg_write(CfgWidth, 13'd4096);
        cfg_write(CfgHeight, 13'd2);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        for (int k = 0; k < 8; k++)
            pix_pending.insert(pix_pending.size(),
                               t_pix_item'{data: 8'($urandom_range(0, 255)), hold: 1'b0});
        drain();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
